// ===== rtl/cnpm_pkg.sv =====
// ----------------------------------------------------------------------------
// cnpm_pkg: shared types and constants for the CAN node presence monitor
// Node table size, register indexes, frame classes and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cnpm_pkg;

	localparam int NODE_COUNT = 8;
	localparam int IDX_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int TS_W       = 32;
	localparam int ID_W       = 11;
	localparam int MASK_W     = 8;
	localparam int CLS_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [TS_W-1:0] FAST_TIMEOUT_RST   = 32'd5000;
	localparam logic [TS_W-1:0] SLOW_TIMEOUT_RST   = 32'd2000000;
	localparam logic [TS_W-1:0] STATUS_TIMEOUT_RST = 32'd5000000;

	localparam logic [2:0] GRP_HIGH     = 3'h1;
	localparam logic [2:0] GRP_LOW      = 3'h3;
	localparam logic [6:0] GRP_TP_FIRST = 7'h71;
	localparam logic [6:0] GRP_TP_OTHER = 7'h73;

	typedef enum logic [CLS_W-1:0] {
		CLS_NONE      = 2'd0,
		CLS_HIGH      = 2'd1,
		CLS_LOW       = 2'd2,
		CLS_TRANSPORT = 2'd3
	} frame_class_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GATEWAY_MODE   = 2'd0,
		REG_FAST_TIMEOUT   = 2'd1,
		REG_SLOW_TIMEOUT   = 2'd2,
		REG_STATUS_TIMEOUT = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FRAME = 4'b0010,
		ST_SWEEP = 4'b0100,
		ST_DONE  = 4'b1000
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic frame;
		logic sweep;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic kind;
		logic sweep_last;
		logic out_full;
	} dp_status_t;

endpackage

// ===== rtl/cnpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// cnpm_ctrl: sequencing controller
// Accepts an item, runs one frame update or a node-by-node sweep, then hands
// the result to the output register once it is free.
// ----------------------------------------------------------------------------
module cnpm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 out_ready,
	input  cnpm_pkg::dp_status_t status,
	output cnpm_pkg::dp_cmd_t    cmd
);
	import cnpm_pkg::*;

	ctl_state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = status.kind ? ST_SWEEP : ST_FRAME;
				end
			end
			ST_FRAME: begin
				cmd.frame = 1'b1;
				state_d   = ST_DONE;
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (status.sweep_last)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!status.out_full || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== rtl/cnpm_datapath.sv =====
// ----------------------------------------------------------------------------
// cnpm_datapath: node table, configuration registers and result register
// Decodes frames, applies timeouts one node per sweep step and builds masks.
// ----------------------------------------------------------------------------
module cnpm_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [cnpm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cnpm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           kind,
	input  logic [cnpm_pkg::ID_W-1:0]      can_id,
	input  logic [cnpm_pkg::TS_W-1:0]      now_us,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [cnpm_pkg::CLS_W-1:0]     frame_class,
	output logic [cnpm_pkg::MASK_W-1:0]    online_mask,
	output logic [cnpm_pkg::MASK_W-1:0]    status_valid_mask,
	output logic [cnpm_pkg::MASK_W-1:0]    went_online_mask,
	output logic [cnpm_pkg::MASK_W-1:0]    went_offline_mask,
	input  cnpm_pkg::dp_cmd_t              cmd,
	output cnpm_pkg::dp_status_t           status
);
	import cnpm_pkg::*;

	logic             gateway_q;
	logic [TS_W-1:0]  fast_to_q, slow_to_q, status_to_q;

	logic [ID_W-1:0]  id_q;
	logic [TS_W-1:0]  now_q;
	logic [IDX_W-1:0] sweep_idx_q;
	frame_class_t     cls_q;
	logic [NODE_COUNT-1:0] up_q, down_q;

	logic [NODE_COUNT-1:0] online_q, fast_q, st_valid_q;
	logic [TS_W-1:0]       last_seen_q   [NODE_COUNT];
	logic [TS_W-1:0]       last_status_q [NODE_COUNT];

	logic             out_valid_q;
	logic [CLS_W-1:0] cls_out_q;
	logic [MASK_W-1:0] online_out_q, status_out_q, up_out_q, down_out_q;

	frame_class_t     frame_cls;
	logic [3:0]       nibble;
	logic             in_range, mark;
	logic [IDX_W-1:0] fidx;
	logic [TS_W-1:0]  limit, seen_age, status_age;
	logic             seen_expired, status_expired;

	always_comb begin
		nibble = id_q[3:0];
		fidx   = nibble[IDX_W-1:0];
		in_range = {1'b0, nibble} < 5'(NODE_COUNT);
		if (id_q[10:8] == GRP_HIGH)
			frame_cls = CLS_HIGH;
		else if (id_q[10:8] == GRP_LOW)
			frame_cls = CLS_LOW;
		else if (gateway_q && (id_q[10:4] == GRP_TP_FIRST || id_q[10:4] == GRP_TP_OTHER))
			frame_cls = CLS_TRANSPORT;
		else
			frame_cls = CLS_NONE;
		mark = (frame_cls != CLS_NONE) && in_range;

		limit          = fast_q[sweep_idx_q] ? fast_to_q : slow_to_q;
		seen_age       = now_q - last_seen_q[sweep_idx_q];
		status_age     = now_q - last_status_q[sweep_idx_q];
		seen_expired   = online_q[sweep_idx_q] && (seen_age > limit);
		status_expired = st_valid_q[sweep_idx_q] && (status_age > status_to_q);
	end

	assign status.kind       = kind;
	assign status.sweep_last = (sweep_idx_q == IDX_W'(NODE_COUNT - 1));
	assign status.out_full   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gateway_q   <= 1'b0;
			fast_to_q   <= FAST_TIMEOUT_RST;
			slow_to_q   <= SLOW_TIMEOUT_RST;
			status_to_q <= STATUS_TIMEOUT_RST;
			sweep_idx_q <= '0;
			cls_q       <= CLS_NONE;
			up_q        <= '0;
			down_q      <= '0;
			online_q    <= '0;
			fast_q      <= '0;
			st_valid_q  <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NODE_COUNT; i++) begin
				last_seen_q[i]   <= '0;
				last_status_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_reg_t'(cfg_index))
					REG_GATEWAY_MODE:   gateway_q   <= cfg_data[0];
					REG_FAST_TIMEOUT:   fast_to_q   <= cfg_data;
					REG_SLOW_TIMEOUT:   slow_to_q   <= cfg_data;
					REG_STATUS_TIMEOUT: status_to_q <= cfg_data;
					default: ;
				endcase
			end

			if (cmd.load) begin
				sweep_idx_q <= '0;
				cls_q       <= CLS_NONE;
				up_q        <= '0;
				down_q      <= '0;
			end

			if (cmd.frame) begin
				cls_q <= frame_cls;
				if (mark) begin
					last_seen_q[fidx] <= now_q;
					if (frame_cls == CLS_HIGH)
						fast_q[fidx] <= 1'b1;
					else if (!online_q[fidx])
						fast_q[fidx] <= 1'b0;
					if (!online_q[fidx]) begin
						online_q[fidx] <= 1'b1;
						up_q[fidx]     <= 1'b1;
					end
					if (frame_cls == CLS_LOW) begin
						last_status_q[fidx] <= now_q;
						st_valid_q[fidx]    <= 1'b1;
					end
				end
			end

			if (cmd.sweep) begin
				if (seen_expired) begin
					online_q[sweep_idx_q] <= 1'b0;
					fast_q[sweep_idx_q]   <= 1'b0;
					down_q[sweep_idx_q]   <= 1'b1;
				end
				if (status_expired)
					st_valid_q[sweep_idx_q] <= 1'b0;
				if (!status.sweep_last)
					sweep_idx_q <= sweep_idx_q + 1'b1;
			end

			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q  <= can_id;
			now_q <= now_us;
		end
		if (cmd.emit) begin
			cls_out_q    <= cls_q;
			online_out_q <= MASK_W'(online_q);
			status_out_q <= MASK_W'(st_valid_q);
			up_out_q     <= MASK_W'(up_q);
			down_out_q   <= MASK_W'(down_q);
		end
	end

	assign out_valid         = out_valid_q;
	assign frame_class       = cls_out_q;
	assign online_mask       = online_out_q;
	assign status_valid_mask = status_out_q;
	assign went_online_mask  = up_out_q;
	assign went_offline_mask = down_out_q;

endmodule

// ===== rtl/can_node_presence_monitor.sv =====
// ----------------------------------------------------------------------------
// can_node_presence_monitor: CAN remote node liveness tracker
// Tracks online state, timeouts and status freshness of a small node table.
// ----------------------------------------------------------------------------
// Frame item: the input is loaded, the frame update runs in ST_FRAME, and ST_DONE
//   hands the result to the output register once it is free; the next item is taken in ST_IDLE.
// Tick item: one node per cycle over NODE_COUNT nodes in ST_SWEEP, then ST_DONE hands
//   the result to the output register once it is free; the next item is taken in ST_IDLE.
// Input is taken while an earlier result still waits in the output register.
// Reset clears the node table and loads the default timeouts.
module can_node_presence_monitor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cnpm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cnpm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            kind,
	input  logic [cnpm_pkg::ID_W-1:0]       can_id,
	input  logic [cnpm_pkg::TS_W-1:0]       now_us,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [cnpm_pkg::CLS_W-1:0]      frame_class,
	output logic [cnpm_pkg::MASK_W-1:0]     online_mask,
	output logic [cnpm_pkg::MASK_W-1:0]     status_valid_mask,
	output logic [cnpm_pkg::MASK_W-1:0]     went_online_mask,
	output logic [cnpm_pkg::MASK_W-1:0]     went_offline_mask
);
	import cnpm_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	cnpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	cnpm_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.kind              (kind),
		.can_id            (can_id),
		.now_us            (now_us),
		.out_ready         (out_ready),
		.out_valid         (out_valid),
		.frame_class       (frame_class),
		.online_mask       (online_mask),
		.status_valid_mask (status_valid_mask),
		.went_online_mask  (went_online_mask),
		.went_offline_mask (went_offline_mask),
		.cmd               (cmd),
		.status            (status)
	);

endmodule

// ===== rtl/cnpm_checker.sv =====
// ----------------------------------------------------------------------------
// cnpm_checker: port-level property checks for the presence monitor
// Watches result consistency and output stability at the top-level ports.
// ----------------------------------------------------------------------------
module cnpm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [cnpm_pkg::CLS_W-1:0]      frame_class,
	input logic [cnpm_pkg::MASK_W-1:0]     online_mask,
	input logic [cnpm_pkg::MASK_W-1:0]     status_valid_mask,
	input logic [cnpm_pkg::MASK_W-1:0]     went_online_mask,
	input logic [cnpm_pkg::MASK_W-1:0]     went_offline_mask
);
	import cnpm_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(online_mask)
			&& $stable(status_valid_mask) && $stable(frame_class))
		else $error("result changed while stalled");

	a_up_online: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (went_online_mask & ~online_mask) == '0)
		else $error("node reported up but not online");

	a_down_offline: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (went_offline_mask & online_mask) == '0)
		else $error("node reported down but still online");

	a_frame_no_down: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_class != CLS_NONE |-> went_offline_mask == '0)
		else $error("frame item reported a timeout");

	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> went_online_mask == '0 || went_offline_mask == '0)
		else $error("nodes went up and down in one item");

endmodule

bind can_node_presence_monitor cnpm_checker u_cnpm_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.frame_class       (frame_class),
	.online_mask       (online_mask),
	.status_valid_mask (status_valid_mask),
	.went_online_mask  (went_online_mask),
	.went_offline_mask (went_offline_mask)
);
